### rtl/swle_pkg.sv
// ----------------------------------------------------------------------------
// swle_pkg
// Shared types and constants for the stop-and-wait link engine.
// ----------------------------------------------------------------------------
package swle_pkg;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] REG_NODE_ID     = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

  localparam logic [7:0] ACK_CMD      = 8'hFF;
  localparam logic [7:0] ELAPSED_MAX  = 8'hFF;
  localparam logic [3:0] NODE_ID_RST  = 4'd15;
  localparam logic [7:0] TIMEOUT_RST  = 8'd5;
  localparam logic [7:0] RETRY_RST    = 8'd10;

  typedef struct packed {
    logic [3:0] node_id;
    logic [7:0] ack_timeout_ms;
    logic [7:0] retry_limit;
  } swle_cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  dest_address;
    logic [7:0]  command_byte;
    logic [47:0] payload_bytes;
    logic [63:0] received_packet;
  } swle_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [63:0] tx_packet;
    logic        send_accepted;
    logic        deliver_valid;
    logic [63:0] delivered_packet;
    logic        link_busy;
    logic        link_failed;
  } swle_result_t;

endpackage

### rtl/swle_cfg.sv
// ----------------------------------------------------------------------------
// swle_cfg
// Configuration register file: node address, ack timeout and retry limit.
// ----------------------------------------------------------------------------
module swle_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output swle_pkg::swle_cfg_t cfg
);
  import swle_pkg::*;

  swle_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id        <= NODE_ID_RST;
      cfg_r.ack_timeout_ms <= TIMEOUT_RST;
      cfg_r.retry_limit    <= RETRY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_ID:     cfg_r.node_id        <= cfg_data[3:0];
        REG_ACK_TIMEOUT: cfg_r.ack_timeout_ms <= cfg_data;
        REG_RETRY_LIMIT: cfg_r.retry_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/swle_in_stage.sv
// ----------------------------------------------------------------------------
// swle_in_stage
// Input register: captures one request and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module swle_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  swle_pkg::swle_item_t in_item,
  input  logic                 take,
  output logic                 item_valid,
  output swle_pkg::swle_item_t item
);
  import swle_pkg::*;

  logic       valid_r;
  swle_item_t item_r;
  logic       load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/swle_engine.sv
// ----------------------------------------------------------------------------
// swle_engine
// Link state and per-request decision logic, followed by the result register.
// ----------------------------------------------------------------------------
module swle_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swle_pkg::swle_cfg_t    cfg,
  input  logic                   item_valid,
  input  swle_pkg::swle_item_t   item,
  output logic                   take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output swle_pkg::swle_result_t result
);
  import swle_pkg::*;

  logic         busy_r, busy_nxt;
  logic         failed_r, failed_nxt;
  logic [63:0]  pending_r, pending_nxt;
  logic [7:0]   retry_r, retry_nxt;
  logic [7:0]   elapsed_r, elapsed_nxt;
  logic         out_valid_r;
  swle_result_t res_r, res_nxt;
  logic         fire;

  logic [7:0]   rx_hdr;
  logic [7:0]   rx_cmd;
  logic [7:0]   elapsed_inc;
  logic [8:0]   retry_inc;

  assign take = !out_valid_r || !out_stall;
  assign fire = item_valid && take;

  assign rx_hdr      = item.received_packet[7:0];
  assign rx_cmd      = item.received_packet[15:8];
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_r + 8'd1;
  assign retry_inc   = {1'b0, retry_r} + 9'd1;

  always_comb begin
    busy_nxt    = busy_r;
    failed_nxt  = failed_r;
    pending_nxt = pending_r;
    retry_nxt   = retry_r;
    elapsed_nxt = elapsed_r;
    res_nxt     = '0;
    case (item.cmd)
      CMD_SEND: begin
        if (!busy_r) begin
          pending_nxt = {item.payload_bytes, item.command_byte,
                         cfg.node_id, item.dest_address};
          retry_nxt             = 8'd0;
          elapsed_nxt           = 8'd0;
          busy_nxt              = 1'b1;
          res_nxt.tx_valid      = 1'b1;
          res_nxt.tx_packet     = pending_nxt;
          res_nxt.send_accepted = 1'b1;
        end
      end
      CMD_RECV: begin
        if (rx_hdr[3:0] == cfg.node_id) begin
          if (rx_cmd == ACK_CMD) begin
            busy_nxt = 1'b0;
          end else begin
            res_nxt.deliver_valid    = 1'b1;
            res_nxt.delivered_packet = item.received_packet;
            res_nxt.tx_valid         = 1'b1;
            res_nxt.tx_packet        = {48'h0, ACK_CMD, cfg.node_id, rx_hdr[7:4]};
          end
        end
      end
      CMD_TICK: begin
        if (busy_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= cfg.ack_timeout_ms) begin
            res_nxt.tx_valid  = 1'b1;
            res_nxt.tx_packet = pending_r;
            elapsed_nxt       = 8'd0;
            retry_nxt         = retry_inc[7:0];
            if (retry_inc > {1'b0, cfg.retry_limit}) begin
              busy_nxt   = 1'b0;
              failed_nxt = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res_nxt.link_busy   = busy_nxt;
    res_nxt.link_failed = failed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      failed_r    <= 1'b0;
      retry_r     <= 8'd0;
      elapsed_r   <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        busy_r    <= busy_nxt;
        failed_r  <= failed_nxt;
        retry_r   <= retry_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (take) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pending_r <= pending_nxt;
      res_r     <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("failure flag dropped without reset");

  a_send_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.cmd == CMD_SEND && !busy_r |=> busy_r && out_valid_r && res_r.tx_valid)
    else $error("accepted send did not transmit and go busy");

  a_deliver_acks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.deliver_valid |-> res_r.tx_valid && res_r.tx_packet[15:8] == ACK_CMD)
    else $error("delivered packet without an ack");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(busy_r) && $stable(retry_r) && $stable(elapsed_r))
    else $error("link state changed without a request");

endmodule

### rtl/stop_and_wait_link_engine_top.sv
// ----------------------------------------------------------------------------
// stop_and_wait_link_engine_top
// Stop-and-wait ARQ engine over fixed 8-byte packets.
// ----------------------------------------------------------------------------
// Each request (send, received packet or millisecond tick) yields exactly one
// result. A request passes an input register and is resolved against the link
// state combinationally into a result register, so one request is taken every
// cycle unless out_stall holds a result; the result is presented from the result
// register. While a finished result waits on out_stall the input register takes
// one more request and then stalls. Configuration writes (cfg_index 0 node id,
// 1 ack timeout, 2 retry limit) take effect on the next cycle and are expected
// while no request is in flight.
module stop_and_wait_link_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_dest_address,
  input  logic [7:0]  in_command_byte,
  input  logic [47:0] in_payload_bytes,
  input  logic [63:0] in_received_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [63:0] out_tx_packet,
  output logic        out_send_accepted,
  output logic        out_deliver_valid,
  output logic [63:0] out_delivered_packet,
  output logic        out_link_busy,
  output logic        out_link_failed
);
  import swle_pkg::*;

  swle_cfg_t    cfg;
  swle_item_t   in_item;
  swle_item_t   item;
  logic         item_valid;
  logic         take;
  swle_result_t result;

  assign in_item.cmd             = in_cmd;
  assign in_item.dest_address    = in_dest_address;
  assign in_item.command_byte    = in_command_byte;
  assign in_item.payload_bytes   = in_payload_bytes;
  assign in_item.received_packet = in_received_packet;

  swle_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swle_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  swle_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign out_tx_valid         = result.tx_valid;
  assign out_tx_packet        = result.tx_packet;
  assign out_send_accepted    = result.send_accepted;
  assign out_deliver_valid    = result.deliver_valid;
  assign out_delivered_packet = result.delivered_packet;
  assign out_link_busy        = result.link_busy;
  assign out_link_failed      = result.link_failed;

endmodule
